FILE: src/swm_pkg.sv
// Shared constants for the sliding-window midpoint block.
// No dependencies; used by swm_tap and sliding_window_midpoint_core.
`timescale 1ns / 1ps
`default_nettype none
package swm_pkg;

	localparam int RADIX_BITS = 5;
	localparam int ADDR_W = 3;
	localparam int LEN_W = 11;
	localparam int APB_W = 32;
	localparam logic [LEN_W-1:0] LEN_RESET = 11'd14;

	typedef enum logic {
		REG_WINDOW_LENGTH = 1'b0,
		REG_NONE = 1'b1
	} reg_sel_t;

endpackage
`default_nettype wire

FILE: src/sliding_window_midpoint_core.sv
// Moving-window midpoint (max + min) of a signed sample stream, top level.
// Depends on swm_pkg, swm_cell and swm_tap.
//
//   Channel  Side    Handshake                  Payload
//   s_*      in      s_tvalid / s_tready        s_tdata = sample, s_tlast = series end
//   m_*      out     m_tvalid / m_tready        m_tdata = midpoint, Q32.1
//   APB      config  psel, penable, pready      window_length at byte address 0
//
// A word that gives no result does not hold off the next input. A word that
// gives a result holds the input until the registered select tree, which reads
// the chain at cell window_length - 1, has passed it on to the output register.
// Reset clears the fill count and output control; the chain holds no reset.
// A stalled output word waits in its register while the next input is taken.
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_midpoint_core #(
	parameter int MAX_WINDOW = 1024,
	parameter int SAMPLE_BITS = 32
) (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     s_tvalid,
	output logic                                    s_tready,
	input  wire [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // sample
	input  wire                                     s_tlast,  // series end
	output logic                                    m_tvalid,
	input  wire                                     m_tready,
	output logic [((SAMPLE_BITS + 8) / 8) * 8 - 1:0] m_tdata, // mid_value
	input  wire                                     psel,
	input  wire                                     penable,
	input  wire                                     pwrite,
	input  wire [swm_pkg::ADDR_W-1:0]               paddr,
	input  wire [swm_pkg::APB_W-1:0]                pwdata,
	output logic [swm_pkg::APB_W-1:0]               prdata,
	output logic                                    pready
);

	localparam int IDX_W = $clog2(MAX_WINDOW);
	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int LEVELS = (IDX_W + swm_pkg::RADIX_BITS - 1) / swm_pkg::RADIX_BITS;
	localparam int LV_W = $clog2(LEVELS + 1);
	localparam int OUT_W = ((SAMPLE_BITS + 8) / 8) * 8;

	logic [swm_pkg::LEN_W-1:0] len_q;
	logic [CNT_W-1:0] fill_q;
	logic [LV_W-1:0] cnt_q;
	logic pend_q;
	logic m_tvalid_q;
	logic [SAMPLE_BITS:0] out_q;

	logic [CNT_W-1:0] eff_len;
	logic [CNT_W-1:0] fill_nxt;
	logic [IDX_W-1:0] idx;
	logic accept;
	logic produce;
	logic out_free;
	logic load_out;
	swm_pkg::reg_sel_t reg_sel;
	logic signed [SAMPLE_BITS-1:0] smp;
	logic signed [SAMPLE_BITS-1:0] hi_c [MAX_WINDOW];
	logic signed [SAMPLE_BITS-1:0] lo_c [MAX_WINDOW];
	logic signed [SAMPLE_BITS-1:0] root_hi;
	logic signed [SAMPLE_BITS-1:0] root_lo;

	assign pready = 1'b1;
	assign reg_sel = paddr[2] ? swm_pkg::REG_NONE : swm_pkg::REG_WINDOW_LENGTH;

	always_comb begin
		unique case (reg_sel)
			swm_pkg::REG_WINDOW_LENGTH: prdata = swm_pkg::APB_W'(len_q);
			default:                    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= swm_pkg::LEN_RESET;
		end else if (psel && penable && pwrite && pready &&
			reg_sel == swm_pkg::REG_WINDOW_LENGTH) begin
			len_q <= pwdata[swm_pkg::LEN_W-1:0];
		end
	end

	always_comb begin
		if (len_q == '0) begin
			eff_len = CNT_W'(1);
		end else if (32'(len_q) > MAX_WINDOW) begin
			eff_len = CNT_W'(MAX_WINDOW);
		end else begin
			eff_len = CNT_W'(len_q);
		end
	end

	assign idx = IDX_W'(eff_len - CNT_W'(1));
	assign fill_nxt = (32'(fill_q) < MAX_WINDOW) ? fill_q + CNT_W'(1) : fill_q;
	assign produce = fill_nxt >= eff_len;
	assign smp = s_tdata[SAMPLE_BITS-1:0];

	assign out_free = !m_tvalid_q || m_tready;
	assign load_out = pend_q && (cnt_q == '0) && out_free;
	assign s_tready = !pend_q || load_out;
	assign accept = s_tvalid && s_tready;

	for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
		if (k == 0) begin : g_head
			swm_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
				.clk(clk), .en(accept), .smp(smp),
				.up_hi(smp), .up_lo(smp),
				.hi(hi_c[k]), .lo(lo_c[k])
			);
		end else begin : g_body
			swm_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
				.clk(clk), .en(accept), .smp(smp),
				.up_hi(hi_c[k - 1]), .up_lo(lo_c[k - 1]),
				.hi(hi_c[k]), .lo(lo_c[k])
			);
		end
	end

	swm_tap #(.SAMPLE_BITS(SAMPLE_BITS), .MAX_WINDOW(MAX_WINDOW)) u_tap (
		.clk(clk), .idx(idx), .hi(hi_c), .lo(lo_c),
		.root_hi(root_hi), .root_lo(root_lo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			cnt_q <= '0;
			pend_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				fill_q <= s_tlast ? '0 : fill_nxt;
				pend_q <= produce;
				cnt_q <= LV_W'(LEVELS);
			end else begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - LV_W'(1);
				end
				if (load_out) begin
					pend_q <= 1'b0;
				end
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= {root_hi[SAMPLE_BITS-1], root_hi} + {root_lo[SAMPLE_BITS-1], root_lo};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = OUT_W'(out_q);

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= MAX_WINDOW)
		else $error("fill count above window capacity");

	a_out_from_pending: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(pend_q))
		else $error("output word without a pending result");

	a_result_starts_tree: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && produce) |=> (pend_q && cnt_q == LV_W'(LEVELS)))
		else $error("result word did not start the select tree");

	a_no_accept_in_tree: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q && cnt_q != '0) |-> !accept)
		else $error("input word taken while the tree is busy");
`endif

endmodule
`default_nettype wire

FILE: src/swm_cell.sv
// One cell of the running-extremum chain: holds max and min of the newest k+1 words.
// Stand-alone; instantiated in a row by sliding_window_midpoint_core.
`timescale 1ns / 1ps
`default_nettype none
module swm_cell #(
	parameter int SAMPLE_BITS = 32
) (
	input  wire                          clk,
	input  wire                          en,
	input  wire signed [SAMPLE_BITS-1:0] smp,
	input  wire signed [SAMPLE_BITS-1:0] up_hi,
	input  wire signed [SAMPLE_BITS-1:0] up_lo,
	output logic signed [SAMPLE_BITS-1:0] hi,
	output logic signed [SAMPLE_BITS-1:0] lo
);

	logic signed [SAMPLE_BITS-1:0] hi_q;
	logic signed [SAMPLE_BITS-1:0] lo_q;

	always_ff @(posedge clk) begin
		if (en) begin
			hi_q <= (up_hi > smp) ? up_hi : smp;
			lo_q <= (up_lo < smp) ? up_lo : smp;
		end
	end

	assign hi = hi_q;
	assign lo = lo_q;

endmodule
`default_nettype wire

FILE: src/swm_tap.sv
// Registered selection tree that picks one cell of the chain, 32 inputs per node.
// Depends on swm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module swm_tap #(
	parameter int SAMPLE_BITS = 32,
	parameter int MAX_WINDOW = 1024
) (
	input  wire                                  clk,
	input  wire [$clog2(MAX_WINDOW)-1:0]         idx,
	input  wire signed [SAMPLE_BITS-1:0]         hi [MAX_WINDOW],
	input  wire signed [SAMPLE_BITS-1:0]         lo [MAX_WINDOW],
	output logic signed [SAMPLE_BITS-1:0]        root_hi,
	output logic signed [SAMPLE_BITS-1:0]        root_lo
);

	localparam int RB = swm_pkg::RADIX_BITS;
	localparam int RADIX = 1 << RB;
	localparam int IDX_W = $clog2(MAX_WINDOW);
	localparam int LEVELS = (IDX_W + RB - 1) / RB;
	localparam int SEL_W = RB * LEVELS;
	localparam int PAD = 1 << SEL_W;
	localparam int PW = 2 * SAMPLE_BITS;

	function automatic int lvl_base(input int l);
		int b;
		b = 0;
		for (int j = 1; j < l; j++) begin
			b = b + (PAD >> (RB * j));
		end
		return b;
	endfunction

	localparam int NODES = lvl_base(LEVELS + 1);

	logic [SEL_W-1:0] idx_pad;
	logic [PW-1:0] leaf [PAD];
	logic [PW-1:0] node_q [NODES];

	assign idx_pad = SEL_W'(idx);

	for (genvar k = 0; k < PAD; k++) begin : g_leaf
		if (k < MAX_WINDOW) begin : g_used
			assign leaf[k] = {lo[k], hi[k]};
		end else begin : g_pad
			assign leaf[k] = '0;
		end
	end

	for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
		localparam int NN = PAD >> (RB * l);
		localparam int BASE = lvl_base(l);
		localparam int PREV = lvl_base(l - 1);
		for (genvar n = 0; n < NN; n++) begin : g_node
			logic [PW-1:0] grp [RADIX];
			for (genvar j = 0; j < RADIX; j++) begin : g_in
				if (l == 1) begin : g_from_leaf
					assign grp[j] = leaf[n * RADIX + j];
				end else begin : g_from_node
					assign grp[j] = node_q[PREV + n * RADIX + j];
				end
			end
			always_ff @(posedge clk) begin
				node_q[BASE + n] <= grp[idx_pad[l * RB - 1 -: RB]];
			end
		end
	end

	assign root_hi = node_q[NODES - 1][SAMPLE_BITS-1:0];
	assign root_lo = node_q[NODES - 1][PW-1:SAMPLE_BITS];

endmodule
`default_nettype wire
